@@ rtl/two_queues_shared_array_macros.svh @@
// Assertion macros shared by the two-queue RTL.
`ifndef TWO_QUEUES_SHARED_ARRAY_MACROS_SVH
`define TWO_QUEUES_SHARED_ARRAY_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define TQSA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TQSA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/tqsa_pkg.sv @@
// Shared constants, codes and control/status types of the two-queue block.
`timescale 1ns / 1ps

package tqsa_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int DATA_W    = 32;

   // request codes
   localparam logic [1:0] CMD_PUSH = 2'd0;
   localparam logic [1:0] CMD_POP  = 2'd1;
   localparam logic [1:0] CMD_SHOW = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic       latch;      // capture request beat
      logic       push_wr;    // write store, move write end
      logic       pop_rd;     // read oldest word, move read end
      logic       walk_load;  // point walker at oldest word
      logic       walk_rd;    // read at walker, step it
      logic       emit;       // load a response beat
      logic       emit_last;
      logic       emit_ram;   // response data comes from the store
      logic [1:0] emit_status;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] op;
      logic       full;
      logic       empty;
      logic       walk_end;
   } stat_type;

endpackage

@@ rtl/tqsa_ram.sv @@
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module tqsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tqsa_ctrl.sv @@
// Sequencer for the two-queue block: decodes the captured request and steps the walk.
`timescale 1ns / 1ps

module tqsa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  tqsa_pkg::stat_type stat_i,
   output tqsa_pkg::ctl_type  ctl_o
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_WALK
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      ctl_o    = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl_o.latch = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            unique case (stat_i.op)
               tqsa_pkg::CMD_PUSH: begin
                  ctl_o.emit        = 1'b1;
                  ctl_o.emit_last   = 1'b1;
                  ctl_o.push_wr     = !stat_i.full;
                  ctl_o.emit_status = stat_i.full ? tqsa_pkg::ST_FULL : tqsa_pkg::ST_OK;
               end
               tqsa_pkg::CMD_POP: begin
                  ctl_o.emit        = 1'b1;
                  ctl_o.emit_last   = 1'b1;
                  ctl_o.pop_rd      = !stat_i.empty;
                  ctl_o.emit_ram    = !stat_i.empty;
                  ctl_o.emit_status = stat_i.empty ? tqsa_pkg::ST_EMPTY : tqsa_pkg::ST_OK;
               end
               tqsa_pkg::CMD_SHOW: begin
                  if (stat_i.empty) begin
                     ctl_o.emit        = 1'b1;
                     ctl_o.emit_last   = 1'b1;
                     ctl_o.emit_status = tqsa_pkg::ST_EMPTY;
                  end else begin
                     ctl_o.walk_load = 1'b1;
                     state_in        = S_WALK;
                  end
               end
               default: begin
                  // unused code: dropped without a response
               end
            endcase
         end
         S_WALK: begin
            ctl_o.walk_rd     = 1'b1;
            ctl_o.emit        = 1'b1;
            ctl_o.emit_ram    = 1'b1;
            ctl_o.emit_status = tqsa_pkg::ST_OK;
            ctl_o.emit_last   = stat_i.walk_end;
            if (stat_i.walk_end) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

@@ rtl/tqsa_dp.sv @@
// Datapath: queue end pointers, shared store, walk pointer and response registers.
`timescale 1ns / 1ps
`include "two_queues_shared_array_macros.svh"

module tqsa_dp #(
   parameter int DEPTH = tqsa_pkg::DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tqsa_pkg::ctl_type                 ctl_i,
   output tqsa_pkg::stat_type                stat_o,
   input  logic [1:0]                        req_cmd,
   input  logic                              req_queue_sel,
   input  logic signed [tqsa_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic signed [tqsa_pkg::DATA_W-1:0] rsp_data,
   output logic                              rsp_last
);

   localparam int IW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);

   // queue 0 grows up from slot 0, queue 1 grows down from the top
   logic [IW-1:0] lw_ff, lw_in, lr_ff, lr_in, hw_ff, hw_in, hr_ff, hr_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [1:0]    op_ff, op_in;
   logic          sel_ff, sel_in;
   logic [tqsa_pkg::DATA_W-1:0] val_ff, val_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_ram_ff, rsp_ram_in;

   logic [IW-1:0] hw_m1, hr_m1;
   logic [AW-1:0] ram_addr;
   logic [tqsa_pkg::DATA_W-1:0] ram_rdata;

   assign hw_m1 = hw_ff - 1'b1;
   assign hr_m1 = hr_ff - 1'b1;

   assign stat_o.op       = op_ff;
   assign stat_o.full     = (lw_ff >= hw_ff);
   assign stat_o.empty    = sel_ff ? (hr_ff <= hw_ff) : (lr_ff >= lw_ff);
   assign stat_o.walk_end = sel_ff ? (IW'(ptr_ff) == hw_ff)
                                   : ((IW'(ptr_ff) + 1'b1) == lw_ff);

   always_comb begin
      if (ctl_i.push_wr) begin
         ram_addr = sel_ff ? hw_m1[AW-1:0] : lw_ff[AW-1:0];
      end else if (ctl_i.pop_rd) begin
         ram_addr = sel_ff ? hr_m1[AW-1:0] : lr_ff[AW-1:0];
      end else begin
         ram_addr = ptr_ff;
      end
   end

   tqsa_ram #(
      .WIDTH (tqsa_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctl_i.push_wr),
      .addr    (ram_addr),
      .wr_data (val_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      lw_in  = lw_ff;
      lr_in  = lr_ff;
      hw_in  = hw_ff;
      hr_in  = hr_ff;
      ptr_in = ptr_ff;
      op_in  = op_ff;
      sel_in = sel_ff;
      val_in = val_ff;
      if (ctl_i.latch) begin
         op_in  = req_cmd;
         sel_in = req_queue_sel;
         val_in = req_value;
      end
      if (ctl_i.push_wr) begin
         if (sel_ff) begin
            hw_in = hw_m1;
         end else begin
            lw_in = lw_ff + 1'b1;
         end
      end
      if (ctl_i.pop_rd) begin
         if (sel_ff) begin
            hr_in = hr_m1;
         end else begin
            lr_in = lr_ff + 1'b1;
         end
      end
      if (ctl_i.walk_load) begin
         ptr_in = sel_ff ? hr_m1[AW-1:0] : lr_ff[AW-1:0];
      end
      if (ctl_i.walk_rd) begin
         // wraps harmlessly after the final beat
         ptr_in = sel_ff ? (ptr_ff - 1'b1) : (ptr_ff + 1'b1);
      end
      rsp_valid_in  = ctl_i.emit;
      rsp_status_in = ctl_i.emit_status;
      rsp_last_in   = ctl_i.emit_last;
      rsp_ram_in    = ctl_i.emit_ram;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_ff        <= '0;
         lr_ff        <= '0;
         hw_ff        <= IW'(DEPTH);
         hr_ff        <= IW'(DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         lw_ff        <= lw_in;
         lr_ff        <= lr_in;
         hw_ff        <= hw_in;
         hr_ff        <= hr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff        <= ptr_in;
      op_ff         <= op_in;
      sel_ff        <= sel_in;
      val_ff        <= val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_ram_ff    <= rsp_ram_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;
   // store read data is already registered; only a zero mux follows it
   assign rsp_data   = rsp_ram_ff ? ram_rdata : '0;

   `TQSA_ASSERT_NOW(a_ends_ordered, 1'b1,
      (lr_ff <= lw_ff) && (lw_ff <= hw_ff) && (hw_ff <= hr_ff) && (hr_ff <= IW'(DEPTH)),
      "queue pointers out of order")
   `TQSA_ASSERT_NOW(a_no_write_when_full, ctl_i.push_wr, lw_ff < hw_ff,
      "store written with queues full")
   `TQSA_ASSERT_NEXT(a_read_beat_follows, ctl_i.pop_rd || ctl_i.walk_rd,
      rsp_valid_ff && rsp_ram_ff && (rsp_status_ff == tqsa_pkg::ST_OK),
      "store read without a data beat")
   `TQSA_ASSERT_NOW(a_walk_in_range, ctl_i.walk_rd,
      sel_ff ? ((IW'(ptr_ff) >= hw_ff) && (IW'(ptr_ff) < hr_ff))
             : ((IW'(ptr_ff) >= lr_ff) && (IW'(ptr_ff) < lw_ff)),
      "walk pointer outside held words")

endmodule

@@ rtl/two_queues_shared_array.sv @@
// Push, pop and empty show: a busy execute state, then one response beat.
// Show of N words: a busy execute state, then a busy walk of N store reads, one beat per cycle,
//   each beat in the cycle after its store read.
// A new request may be taken in the cycle that carries the final response beat.
// Synchronous active-high reset empties both queues; store contents are not cleared.
// Responses cannot be stalled: each beat is valid for exactly one cycle.
`timescale 1ns / 1ps

module two_queues_shared_array #(
   parameter int DEPTH = tqsa_pkg::DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_cmd,
   input  logic                               req_queue_sel,
   input  logic signed [tqsa_pkg::DATA_W-1:0] req_value,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic signed [tqsa_pkg::DATA_W-1:0] rsp_data,
   output logic                               rsp_last
);

   tqsa_pkg::ctl_type  ctl;
   tqsa_pkg::stat_type stat;

   tqsa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .stat_i (stat),
      .ctl_o  (ctl)
   );

   tqsa_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctl_i         (ctl),
      .stat_o        (stat),
      .req_cmd       (req_cmd),
      .req_queue_sel (req_queue_sel),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_data      (rsp_data),
      .rsp_last      (rsp_last)
   );

endmodule
